[sv/dlb_pkg.sv]
// ----------------------------------------------------------------------------
// dlb_pkg: shared types and constants for the discrete log solver
// Command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package dlb_pkg;

  localparam int unsigned ModBitsDefault = 12;

  // datapath operations
  typedef enum logic [3:0] {
    OpNone    = 4'd0,
    OpLoad    = 4'd1,  // latch operands, start base reduction
    OpRedA    = 4'd2,  // latch reduced base, start target reduction
    OpRedB    = 4'd3,  // latch reduced target
    OpSqrt    = 4'd4,  // one isqrt bit step
    OpPowInit = 4'd5,  // an = 1 % m, counter = 0
    OpPowMul  = 4'd6,  // an = an * a mod m
    OpClr     = 4'd7,  // clear one table entry
    OpGInit   = 4'd8,  // cur = an, i = 1
    OpGMul    = 4'd9,  // record cur, cur = cur * an mod m
    OpBInit   = 4'd10, // cur = b, i = 0
    OpBRead   = 4'd11, // no datapath action; the table read at cur runs unconditionally
    OpBChk    = 4'd12  // check read data, cur = cur * a mod m
  } dlb_op_e;

  typedef struct packed {
    dlb_op_e op;
    logic    mul_go;   // start a modular multiply
  } dlb_cmd_t;

  typedef struct packed {
    logic mod_zero;    // modulus is zero
    logic mul_busy;    // multiply/reduce unit working
    logic sqrt_done;   // isqrt finished
    logic cnt_last;    // loop counter at its end
    logic hit;         // scan hit with valid exponent
  } dlb_sts_t;

endpackage

[sv/dlb_mulmod.sv]
// ----------------------------------------------------------------------------
// dlb_mulmod: sequential modular multiplier
// Computes (x * y) mod m by shift-and-add, first reducing x over its bits,
// then one multiplier bit a cycle; y = 1 gives a plain reduction x mod m.
// ----------------------------------------------------------------------------
module dlb_mulmod import dlb_pkg::*; #(
  parameter int unsigned ModBits = ModBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic [ModBits-1:0] x_i,
  input  logic [ModBits-1:0] y_i,
  input  logic [ModBits-1:0] m_i,
  output logic               busy_o,
  output logic [ModBits-1:0] res_o
);
  localparam int unsigned CntW = $clog2(ModBits + 1);

  logic [ModBits:0]   acc_q, acc_d;
  logic [ModBits:0]   xr_q, xr_d;   // x shifted out from the top, then x mod m
  logic [ModBits-1:0] y_q, y_d;
  logic [ModBits-1:0] m_q, m_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               pre_q, pre_d; // x reduction phase
  logic [ModBits:0]   sum, dbl;

  // reduce x first by repeated compare/subtract via the same loop:
  // x mod m computed as sum of bits of x times 2^k mod m
  always_comb begin
    acc_d  = acc_q;
    xr_d   = xr_q;
    y_d    = y_q;
    m_d    = m_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    pre_d  = pre_q;
    sum    = '0;
    dbl    = '0;
    if (go_i) begin
      // phase 1: reduce x, scanning its bits from the top (Horner)
      acc_d  = '0;
      xr_d   = {1'b0, x_i};
      y_d    = y_i;
      m_d    = m_i;
      cnt_d  = CntW'(ModBits);
      busy_d = 1'b1;
      pre_d  = 1'b1;
    end else if (busy_q) begin
      if (pre_q) begin
        // acc = 2*acc + bit, then mod m (one subtract suffices)
        sum = {acc_q[ModBits-1:0], xr_q[ModBits-1]};
        if (sum >= {1'b0, m_q}) sum = sum - {1'b0, m_q};
        acc_d = sum;
        xr_d  = {xr_q[ModBits-1:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          pre_d = 1'b0;
          xr_d  = sum;          // reduced x
          acc_d = '0;
          cnt_d = CntW'(ModBits);
        end
      end else begin
        // Horner over y bits from the top: acc = 2*acc (+ xr) mod m
        dbl = {acc_q[ModBits-1:0], 1'b0};
        if (dbl >= {1'b0, m_q}) dbl = dbl - {1'b0, m_q};
        sum = dbl;
        if (y_q[ModBits-1]) begin
          sum = dbl + xr_q;
          if (sum >= {1'b0, m_q}) sum = sum - {1'b0, m_q};
        end
        acc_d = sum;
        y_d   = {y_q[ModBits-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pre_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pre_q  <= pre_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    xr_q  <= xr_d;
    y_q   <= y_d;
    m_q   <= m_d;
  end

  assign busy_o = busy_q;
  assign res_o  = acc_q[ModBits-1:0];
endmodule

[sv/dlb_datapath.sv]
// ----------------------------------------------------------------------------
// dlb_datapath: operand registers, table memory and loop counters
// Carries out one controller command a cycle; the multiplier runs
// alongside and reports busy.
// ----------------------------------------------------------------------------
module dlb_datapath import dlb_pkg::*; #(
  parameter int unsigned ModBits = ModBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dlb_cmd_t           cmd_i,
  input  logic [ModBits-1:0] base_i,
  input  logic [ModBits-1:0] target_i,
  input  logic [ModBits-1:0] modulus_i,
  output dlb_sts_t           sts_o,
  output logic [ModBits-1:0] exponent_o
);
  localparam int unsigned Depth = 1 << ModBits;
  localparam int unsigned SqW   = (ModBits + 1) / 2;   // isqrt width
  localparam int unsigned StW   = SqW + 1;             // step width
  localparam int unsigned BitW  = $clog2(SqW + 1);

  logic [ModBits-1:0] a_q, b_q, m_q, an_q, cur_q, tgt_q;
  logic [StW-1:0]     step_q, i_q;
  logic [ModBits-1:0] clr_q;
  logic [SqW-1:0]     root_q;
  logic [BitW-1:0]    sbit_q;
  logic               sqrt_done_q;
  logic               hit_q;
  logic [ModBits-1:0] exp_q;
  logic               mul_by_a_q;   // loop multiplies by a, else by an

  // table memory, one write port and one read port, registered read
  logic [StW-1:0]     tbl_mem [Depth];
  logic [StW-1:0]     rd_q;
  logic               wr_en;
  logic [ModBits-1:0] wr_addr;
  logic [StW-1:0]     wr_data;

  logic               mul_busy;
  logic [ModBits-1:0] mul_res, mx, my;
  logic [SqW-1:0]     trial;
  logic [2*SqW-1:0]   trial_sq;
  logic [2*StW-1:0]   prod;
  logic [2*StW-1:0]   xval;
  logic               cnt_last;

  // multiplier operand select; loop multiplies take cur times a or an
  always_comb begin
    mx = cur_q;
    my = mul_by_a_q ? a_q : an_q;
    unique case (cmd_i.op)
      OpLoad:   begin mx = base_i;   my = ModBits'(1); end
      OpRedA:   begin mx = tgt_q;    my = ModBits'(1); end
      default:  begin mx = cur_q;    my = mul_by_a_q ? a_q : an_q; end
    endcase
  end

  dlb_mulmod #(.ModBits(ModBits)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.mul_go),
    .x_i    (mx),
    .y_i    (my),
    .m_i    ((cmd_i.op == OpLoad) ? modulus_i : m_q),
    .busy_o (mul_busy),
    .res_o  (mul_res)
  );

  assign trial    = root_q | (SqW'(1) << sbit_q);
  assign trial_sq = trial * trial;
  assign prod     = {{StW{1'b0}}, rd_q} * {{StW{1'b0}}, step_q};
  assign xval     = prod - (2*StW)'(i_q);

  // table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = '0;
    if (cmd_i.op == OpClr) begin
      wr_en = 1'b1;
    end else if (cmd_i.op == OpGMul && rd_q == '0) begin
      wr_en   = 1'b1;
      wr_addr = cur_q;
      wr_data = i_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) tbl_mem[wr_addr] <= wr_data;
    rd_q <= tbl_mem[cur_q];
  end

  // control-type registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqrt_done_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OpLoad:  begin sqrt_done_q <= 1'b0; hit_q <= 1'b0; end
        OpSqrt:  sqrt_done_q <= (sbit_q == '0);
        OpBChk:  hit_q <= (rd_q != '0) && (xval < (2*StW)'(m_q));
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpLoad: begin
        m_q    <= modulus_i;
        tgt_q  <= target_i;
        root_q <= '0;
        sbit_q <= BitW'(SqW - 1);
        exp_q  <= '0;
      end
      OpRedA: a_q <= mul_res;
      OpRedB: b_q <= mul_res;
      OpSqrt: begin
        if ((2*SqW)'(m_q) >= trial_sq) root_q <= trial;
        sbit_q <= sbit_q - 1'b1;
      end
      OpPowInit: begin
        step_q     <= {1'b0, root_q} + StW'(1);
        an_q       <= (m_q == ModBits'(1)) ? '0 : ModBits'(1);
        cur_q      <= (m_q == ModBits'(1)) ? '0 : ModBits'(1);
        mul_by_a_q <= 1'b1;
        i_q        <= '0;
        clr_q      <= '0;
      end
      OpPowMul: begin
        an_q  <= mul_res;
        cur_q <= mul_res;
        i_q   <= i_q + 1'b1;
      end
      OpClr: clr_q <= clr_q + 1'b1;
      OpGInit: begin
        cur_q      <= an_q;
        mul_by_a_q <= 1'b0;
        i_q        <= StW'(1);
      end
      OpGMul: begin
        cur_q <= mul_res;
        i_q   <= i_q + 1'b1;
      end
      OpBInit: begin
        cur_q      <= b_q;
        mul_by_a_q <= 1'b1;
        i_q        <= '0;
      end
      OpBChk: begin
        if ((rd_q != '0) && (xval < (2*StW)'(m_q))) exp_q <= xval[ModBits-1:0];
        cur_q <= mul_res;
        i_q   <= i_q + 1'b1;
      end
      default: ;
    endcase
  end

  // counter end: pow loop i == step after this step, gloop, scan, clear
  always_comb begin
    cnt_last = 1'b0;
    unique case (cmd_i.op)
      OpPowMul: cnt_last = (i_q == step_q - 1'b1);
      OpClr:    cnt_last = (clr_q == m_q - 1'b1);
      OpGMul:   cnt_last = (i_q == step_q);
      OpBChk:   cnt_last = (i_q == step_q);
      default:  cnt_last = 1'b0;
    endcase
  end

  assign sts_o.cnt_last  = cnt_last;
  assign sts_o.mod_zero  = (m_q == '0);
  assign sts_o.mul_busy  = mul_busy;
  assign sts_o.sqrt_done = sqrt_done_q;
  assign sts_o.hit       = hit_q;
  assign exponent_o      = exp_q;
endmodule

[sv/dlb_ctrl.sv]
// ----------------------------------------------------------------------------
// dlb_ctrl: sequencing state machine
// Walks reduce, isqrt, power, clear, giant-step and scan phases, waiting
// on the multiplier between steps.
// ----------------------------------------------------------------------------
module dlb_ctrl import dlb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dlb_sts_t sts_i,
  output dlb_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o
);
  typedef enum logic [13:0] {
    StIdle  = 14'b00000000000001,
    StZchk  = 14'b00000000000010,
    StRedA  = 14'b00000000000100,
    StRedB  = 14'b00000000001000,
    StSqrt  = 14'b00000000010000,
    StPowI  = 14'b00000000100000,
    StPow   = 14'b00000001000000,
    StClr   = 14'b00000010000000,
    StGInit = 14'b00000100000000,
    StGRd   = 14'b00001000000000,
    StGMul  = 14'b00010000000000,
    StBRd   = 14'b00100000000000,
    StBChk  = 14'b01000000000000,
    StDone  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   wait_q, wait_d;   // multiply in flight (StPow) or scan initialised (StBRd)
  logic   last_q, last_d;

  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    last_d  = last_q;
    cmd_o   = '{op: OpNone, mul_go: 1'b0};
    done_o  = 1'b0;
    unique case (state_q)
      StIdle: if (start_i) begin
        cmd_o   = '{op: OpNone, mul_go: 1'b0};
        state_d = StZchk;
      end
      // operands are latched on the start transfer (see top)
      StZchk: begin
        if (sts_i.mod_zero) state_d = StDone;
        else begin
          cmd_o   = '{op: OpNone, mul_go: 1'b0};
          state_d = StRedA;
          wait_d  = 1'b0;
        end
      end
      // base reduction runs from the start transfer; then reduce target
      StRedA: if (!sts_i.mul_busy) begin
        cmd_o   = '{op: OpRedA, mul_go: 1'b1};
        state_d = StRedB;
      end
      StRedB: if (!sts_i.mul_busy) begin
        cmd_o   = '{op: OpRedB, mul_go: 1'b0};
        state_d = StSqrt;
      end
      StSqrt: begin
        if (sts_i.sqrt_done) state_d = StPowI;
        else cmd_o = '{op: OpSqrt, mul_go: 1'b0};
      end
      StPowI: begin
        cmd_o   = '{op: OpPowInit, mul_go: 1'b0};
        state_d = StPow;
        wait_d  = 1'b0;
      end
      StPow: begin
        if (!wait_q) begin
          cmd_o  = '{op: OpNone, mul_go: 1'b1};
          wait_d = 1'b1;
        end else if (!sts_i.mul_busy) begin
          cmd_o  = '{op: OpPowMul, mul_go: 1'b0};
          wait_d = 1'b0;
          if (sts_i.cnt_last) state_d = StClr;
        end
      end
      StClr: begin
        cmd_o = '{op: OpClr, mul_go: 1'b0};
        if (sts_i.cnt_last) state_d = StGInit;
      end
      StGInit: begin
        cmd_o   = '{op: OpGInit, mul_go: 1'b0};
        state_d = StGRd;
        wait_d  = 1'b0;
      end
      // read slot, then multiply and conditional write
      StGRd: begin
        cmd_o   = '{op: OpNone, mul_go: 1'b1};
        state_d = StGMul;
      end
      StGMul: if (!sts_i.mul_busy) begin
        cmd_o = '{op: OpGMul, mul_go: 1'b0};
        if (sts_i.cnt_last) state_d = StBRd;
        else state_d = StGRd;
        if (sts_i.cnt_last) begin
          cmd_o   = '{op: OpGMul, mul_go: 1'b0};
          last_d  = 1'b0;
        end
      end
      StBRd: begin
        if (last_q && sts_i.hit) state_d = StDone;
        else if (last_q) state_d = StDone;
        else begin
          if (!wait_q) begin
            cmd_o  = '{op: OpBInit, mul_go: 1'b0};
            wait_d = 1'b1;
          end else begin
            cmd_o   = '{op: OpNone, mul_go: 1'b1};
            state_d = StBChk;
          end
        end
      end
      StBChk: begin
        if (sts_i.hit) state_d = StDone;
        else if (!sts_i.mul_busy) begin
          cmd_o  = '{op: OpBChk, mul_go: 1'b0};
          last_d = sts_i.cnt_last;
          state_d = StBRd;
        end
      end
      StDone: begin
        done_o  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StIdle) last_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wait_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      last_q  <= last_d;
    end
  end

  assign busy_o = (state_q != StIdle);
endmodule

[sv/discrete_log_bsgs.sv]
// ----------------------------------------------------------------------------
// discrete_log_bsgs: baby-step giant-step discrete logarithm solver
// A zero modulus skips the search and goes straight to the result strobe.
// One item at a time, busy drops as the strobe rises; results cannot be
// stalled. Reset idles the controller; the table is cleared per item.
// ----------------------------------------------------------------------------
module discrete_log_bsgs import dlb_pkg::*; #(
  parameter int unsigned MOD_BITS = ModBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [MOD_BITS-1:0] base_i,
  input  logic [MOD_BITS-1:0] target_i,
  input  logic [MOD_BITS-1:0] modulus_i,
  output logic                valid_o,
  output logic                found_o,
  output logic [MOD_BITS-1:0] exponent_o
);
  dlb_cmd_t cmd, dp_cmd;
  dlb_sts_t sts;
  logic     done, start_xfer;
  logic [MOD_BITS-1:0] exp_dp;
  logic     found_q, valid_q;
  logic [MOD_BITS-1:0] exp_q;

  assign start_xfer = start && !busy;

  // load operands on the start transfer; reduce base at once
  always_comb begin
    dp_cmd = cmd;
    if (start_xfer) dp_cmd = '{op: OpLoad, mul_go: 1'b1};
  end

  dlb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done)
  );

  dlb_datapath #(.ModBits(MOD_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .base_i     (base_i),
    .target_i   (target_i),
    .modulus_i  (modulus_i),
    .sts_o      (sts),
    .exponent_o (exp_dp)
  );

  // result register, one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      found_q <= 1'b0;
      exp_q   <= '0;
    end else begin
      valid_q <= done;
      if (done) begin
        found_q <= sts.hit;
        exp_q   <= sts.hit ? exp_dp : '0;
      end
    end
  end

  assign valid_o    = valid_q;
  assign found_o    = found_q;
  assign exponent_o = exp_q;
endmodule
